// ===== hdl/uv_disparity_histogram_unit_macros.svh =====
// Assertion macros shared by the u/v-disparity histogram unit.
`ifndef UV_DISPARITY_HISTOGRAM_UNIT_MACROS_SVH
`define UV_DISPARITY_HISTOGRAM_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UVDH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvdh assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UVDH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvdh assertion failed");

`endif

// ===== hdl/uvdh_pkg.sv =====
// Package with the widths, codes and types of the u/v-disparity histogram unit.
package uvdh_pkg;

    localparam int DISP_BINS_DEF = 128;
    localparam int MAX_ROWS_DEF  = 512;
    localparam int MAX_COLS_DEF  = 1024;

    localparam int CMD_W      = 2;
    localparam int ROW_W      = 9;
    localparam int COL_W      = 10;
    localparam int DISP_W     = 8;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int FW_W       = 11;
    localparam int FH_W       = 10;
    localparam int TLC_W      = 10;

    // Divider operand widths for the left edge of the counting region.
    localparam int PROD_W = TLC_W + ROW_W;
    localparam int SPAN_W = FH_W;
    localparam int Q_W    = TLC_W;

    localparam logic [CNT_W-1:0] SAT_MAX = 8'd255;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACC = 2'd0,
        CMD_RDV = 2'd1,
        CMD_RDU = 2'd2,
        CMD_CLR = 2'd3
    } uvdh_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_TOP_ROW       = 3'd2,
        CFG_TOP_LEFT_COL  = 3'd3,
        CFG_DISP_FLOOR    = 3'd4,
        CFG_COUNT_FLOOR   = 3'd5,
        CFG_ENABLE_U      = 3'd6,
        CFG_ENABLE_V      = 3'd7
    } uvdh_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE,
        ST_DIV,
        ST_BUMP,
        ST_READ,
        ST_SEND
    } uvdh_state_t;

endpackage

// ===== hdl/uvdh_if.sv =====
// Stream interfaces for the input items and the result items.
interface uvdh_item_if
    import uvdh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DISP_W-1:0] disparity;

    modport source (output valid, output cmd, output row, output col, output disparity,
                    input ready);
    modport sink   (input valid, input cmd, input row, input col, input disparity,
                    output ready);
endinterface

interface uvdh_result_if
    import uvdh_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] bin_count;
    logic             strong_res;

    modport source (output valid, output bin_count, output strong_res, input ready);
    modport sink   (input valid, input bin_count, input strong_res, output ready);
endinterface

// ===== hdl/uvdh_div.sv =====
// Radix-2 restoring divider that finds the left-edge offset, one quotient bit a cycle.
module uvdh_div
    import uvdh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [SPAN_W-1:0] divisor,
    output logic              done,
    output logic [Q_W-1:0]    quotient
);

    localparam int STEP_W = $clog2(Q_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SPAN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]    low_reg, low_next;
    logic [Q_W-1:0]    quot_reg, quot_next;
    logic [SPAN_W-1:0] divisor_reg, divisor_next;

    logic [SPAN_W:0]   trial;
    logic [SPAN_W:0]   diff;
    logic              fits;

    // The quotient is known to be below 2**Q_W, so the upper dividend bits
    // already form a partial remainder smaller than the divisor.
    always_comb
    begin
        trial = {rem_reg, low_reg[Q_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        fits  = (trial >= {1'b0, divisor_reg});

        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;

        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = SPAN_W'(dividend[PROD_W-1:Q_W]);
            low_next     = dividend[Q_W-1:0];
            quot_next    = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
            low_next  = {low_reg[Q_W-2:0], 1'b0};
            quot_next = {quot_reg[Q_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        low_reg     <= low_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== hdl/uv_disparity_histogram_unit.sv =====
// The unit keeps a v-disparity histogram (row by disparity) and a u-disparity histogram
// (disparity by column) of saturating 8-bit bins in two single-port synchronous memories,
// and serves one command at a time. A pixel that fails the row or disparity bounds or lies
// outside the store is dropped as it is accepted. A pixel that passes them goes on to an
// edge check, which ends it when it falls outside the column span of its row and else
// reads its bins, which are then written back to the enabled histograms; this holds while
// it stays on the row whose left edge was computed last. On a new row, or after a
// configuration write, the edge check first starts the serial divider that computes the
// left edge of the counting region for that row and is then repeated. A bin read's result
// waits in an output register, so the next command is taken meanwhile; if that register
// is still full, the read is repeated until it frees. After reset and after a clear command
// the unit sweeps both memories, one address a cycle, over all
// DISP_BINS * max(MAX_ROWS, MAX_COLS) addresses (131072 with the defaults) and takes no item
// during that time; configuration writes are taken at any time.
`include "uv_disparity_histogram_unit_macros.svh"

module uv_disparity_histogram_unit
    import uvdh_pkg::*;
#(
    parameter int DISP_BINS = DISP_BINS_DEF,
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    uvdh_item_if.sink             item,
    uvdh_result_if.source         result
);

    localparam int V_DEPTH   = MAX_ROWS * DISP_BINS;
    localparam int U_DEPTH   = DISP_BINS * MAX_COLS;
    localparam int VA_W      = $clog2(V_DEPTH);
    localparam int UA_W      = $clog2(U_DEPTH);
    localparam int CLR_DEPTH = (V_DEPTH > U_DEPTH) ? V_DEPTH : U_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // Configuration registers.
    logic [FW_W-1:0]   frame_width_reg;
    logic [FH_W-1:0]   frame_height_reg;
    logic [ROW_W-1:0]  top_row_reg;
    logic [TLC_W-1:0]  top_left_column_reg;
    logic [DISP_W-1:0] disparity_floor_reg;
    logic [CNT_W-1:0]  count_floor_reg;
    logic              enable_u_reg;
    logic              enable_v_reg;

    uvdh_state_t       state_reg, state_next;
    logic [CLR_W-1:0]  clr_cnt_reg, clr_cnt_next;

    // Held command.
    uvdh_cmd_t         cmd_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic              rd_ok_reg;
    logic [VA_W-1:0]   addr_v_reg;
    logic [UA_W-1:0]   addr_u_reg;

    // Left edge of the row whose edge was computed last.
    logic              edge_valid_reg, edge_valid_next;
    logic [ROW_W-1:0]  edge_row_reg;
    logic [TLC_W-1:0]  edge_left_reg;

    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_strong_reg;

    logic [CNT_W-1:0]  v_hist_mem [V_DEPTH];
    logic [CNT_W-1:0]  u_hist_mem [U_DEPTH];
    logic [CNT_W-1:0]  v_rdata_reg;
    logic [CNT_W-1:0]  u_rdata_reg;

    uvdh_cmd_t         item_cmd;
    logic              item_acc;
    logic              pix_pass;
    logic              read_ok;
    logic              edge_hit;
    logic              col_in;
    logic              clr_last;
    logic              out_free;

    logic              v_re, u_re, v_we, u_we;
    logic [VA_W-1:0]   v_waddr;
    logic [UA_W-1:0]   u_waddr;
    logic [CNT_W-1:0]  v_wdata, u_wdata;
    logic              out_load;
    logic [CNT_W-1:0]  out_count;
    logic              edge_load;
    logic              div_start;
    logic              div_done;
    logic [Q_W-1:0]    div_quot;
    logic [ROW_W-1:0]  row_off;
    logic [PROD_W-1:0] div_dividend;
    logic [SPAN_W-1:0] div_span;

    assign item_cmd = uvdh_cmd_t'(item.cmd);
    assign item_acc = item.valid && item.ready;

    always_comb
    begin
        pix_pass = (item.disparity > disparity_floor_reg)
                && (int'(item.disparity) < DISP_BINS)
                && (item.row >= top_row_reg)
                && ({1'b0, item.row} < frame_height_reg)
                && (int'(item.row) < MAX_ROWS)
                && (int'(item.col) < MAX_COLS);
        if (item_cmd == CMD_RDV)
        begin
            read_ok = (int'(item.row) < MAX_ROWS) && (int'(item.disparity) < DISP_BINS);
        end
        else
        begin
            read_ok = (int'(item.col) < MAX_COLS) && (int'(item.disparity) < DISP_BINS);
        end
    end

    assign edge_hit = edge_valid_reg && (edge_row_reg == row_reg);
    assign col_in   = (col_reg >= edge_left_reg)
                   && (({1'b0, col_reg} + {1'b0, edge_left_reg}) < frame_width_reg);
    assign clr_last = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));
    assign out_free = !out_valid_reg || result.ready;

    assign row_off      = row_reg - top_row_reg;
    assign div_dividend = PROD_W'(top_left_column_reg) * PROD_W'(row_off);
    assign div_span     = frame_height_reg - SPAN_W'(top_row_reg);

    uvdh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_span),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Next state.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    case (item_cmd)
                        CMD_ACC: state_next = pix_pass ? ST_EDGE : ST_IDLE;
                        CMD_RDV: state_next = ST_READ;
                        CMD_RDU: state_next = ST_READ;
                        CMD_CLR:
                        begin
                            state_next   = ST_CLEAR;
                            clr_cnt_next = '0;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EDGE:
            begin
                if (!edge_hit)
                begin
                    state_next = ST_DIV;
                end
                else if (col_in)
                begin
                    state_next = ST_BUMP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:  state_next = div_done ? ST_EDGE : ST_DIV;
            ST_BUMP: state_next = ST_IDLE;
            ST_READ: state_next = ST_SEND;
            ST_SEND: state_next = out_free ? ST_IDLE : ST_READ;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the controller.
    always_comb
    begin
        item.ready = (state_reg == ST_IDLE);
        v_re       = 1'b0;
        u_re       = 1'b0;
        v_we       = 1'b0;
        u_we       = 1'b0;
        v_waddr    = addr_v_reg;
        u_waddr    = addr_u_reg;
        v_wdata    = (v_rdata_reg == SAT_MAX) ? v_rdata_reg : v_rdata_reg + 1'b1;
        u_wdata    = (u_rdata_reg == SAT_MAX) ? u_rdata_reg : u_rdata_reg + 1'b1;
        div_start  = 1'b0;
        edge_load  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                v_we    = (int'(clr_cnt_reg) < V_DEPTH);
                u_we    = (int'(clr_cnt_reg) < U_DEPTH);
                v_waddr = clr_cnt_reg[VA_W-1:0];
                u_waddr = clr_cnt_reg[UA_W-1:0];
                v_wdata = '0;
                u_wdata = '0;
            end
            ST_EDGE:
            begin
                div_start = !edge_hit;
                v_re      = edge_hit && col_in;
                u_re      = edge_hit && col_in;
            end
            ST_DIV:  edge_load = div_done;
            ST_BUMP:
            begin
                v_we = enable_v_reg;
                u_we = enable_u_reg;
            end
            ST_READ:
            begin
                v_re = 1'b1;
                u_re = 1'b1;
            end
            ST_SEND: out_load = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        if (!rd_ok_reg)
        begin
            out_count = '0;
        end
        else if (cmd_reg == CMD_RDV)
        begin
            out_count = v_rdata_reg;
        end
        else
        begin
            out_count = u_rdata_reg;
        end
        out_valid_next  = out_load || (out_valid_reg && !result.ready);
        edge_valid_next = cfg_we ? 1'b0 : (edge_valid_reg || edge_load);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_CLEAR;
            clr_cnt_reg         <= '0;
            edge_valid_reg      <= 1'b0;
            out_valid_reg       <= 1'b0;
            frame_width_reg     <= 11'd1024;
            frame_height_reg    <= 10'd512;
            top_row_reg         <= '0;
            top_left_column_reg <= '0;
            disparity_floor_reg <= '0;
            count_floor_reg     <= '0;
            enable_u_reg        <= 1'b1;
            enable_v_reg        <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            edge_valid_reg <= edge_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (uvdh_cfg_idx_t'(cfg_index))
                    CFG_FRAME_WIDTH:  frame_width_reg     <= cfg_data[FW_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg    <= cfg_data[FH_W-1:0];
                    CFG_TOP_ROW:      top_row_reg         <= cfg_data[ROW_W-1:0];
                    CFG_TOP_LEFT_COL: top_left_column_reg <= cfg_data[TLC_W-1:0];
                    CFG_DISP_FLOOR:   disparity_floor_reg <= cfg_data[DISP_W-1:0];
                    CFG_COUNT_FLOOR:  count_floor_reg     <= cfg_data[CNT_W-1:0];
                    CFG_ENABLE_U:     enable_u_reg        <= cfg_data[0];
                    CFG_ENABLE_V:     enable_v_reg        <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            cmd_reg    <= item_cmd;
            row_reg    <= item.row;
            col_reg    <= item.col;
            rd_ok_reg  <= read_ok;
            addr_v_reg <= VA_W'(VA_W'(item.row) * VA_W'(DISP_BINS)) + VA_W'(item.disparity);
            addr_u_reg <= UA_W'(UA_W'(item.disparity) * UA_W'(MAX_COLS)) + UA_W'(item.col);
        end
        if (edge_load)
        begin
            edge_row_reg  <= row_reg;
            edge_left_reg <= top_left_column_reg - div_quot;
        end
        if (out_load)
        begin
            out_count_reg  <= out_count;
            out_strong_reg <= (out_count > count_floor_reg);
        end
    end

    // Histogram memories: one read or one write a cycle, registered read data.
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            v_hist_mem[v_waddr] <= v_wdata;
        end
        if (v_re)
        begin
            v_rdata_reg <= v_hist_mem[addr_v_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (u_we)
        begin
            u_hist_mem[u_waddr] <= u_wdata;
        end
        if (u_re)
        begin
            u_rdata_reg <= u_hist_mem[addr_u_reg];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.bin_count  = out_count_reg;
    assign result.strong_res = out_strong_reg;

    `UVDH_ASSERT_SAME(a_div_done_in_div, div_done, state_reg == ST_DIV)
    `UVDH_ASSERT_SAME(a_edge_left_bound, edge_valid_reg, edge_left_reg <= top_left_column_reg)
    `UVDH_ASSERT_NEXT(a_result_from_read, !out_valid_reg && state_reg != ST_SEND, !out_valid_reg)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the u/v-disparity histogram unit with a bin-count predictor.
module testbench;
    import uvdh_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 400000;
    localparam int RECENT_HITS   = 16;

    typedef struct packed {
        logic [CNT_W-1:0] bin_count;
        logic             strong_res;
    } bin_read_t;

    typedef struct {
        int r;
        int c;
        int d;
    } pixel_t;

    typedef struct {
        bit            is_cfg;
        uvdh_cfg_idx_t reg_idx;
        int            reg_val;
        uvdh_cmd_t     cmd;
        int            r;
        int            c;
        int            d;
        int            reps;
        bit            typed;
        bin_read_t     want;
    } plan_step_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    uvdh_item_if   item_bus();
    uvdh_result_if result_bus();

    uv_disparity_histogram_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_bus),
        .result    (result_bus)
    );

    // Predicted register contents.
    logic [FW_W-1:0]   cur_width       = 11'd1024;
    logic [FH_W-1:0]   cur_height      = 10'd512;
    logic [ROW_W-1:0]  cur_top         = '0;
    logic [TLC_W-1:0]  cur_top_left    = '0;
    logic [DISP_W-1:0] cur_disp_floor  = '0;
    logic [CNT_W-1:0]  cur_count_floor = '0;
    logic              cur_en_u        = 1'b1;
    logic              cur_en_v        = 1'b1;

    // Sparse copies of the two histograms; a missing key is a zero bin.
    logic [CNT_W-1:0] v_bins [int];
    logic [CNT_W-1:0] u_bins [int];

    bin_read_t pending_reads [$];
    pixel_t    recent_hits [$];

    int errors       = 0;
    int quiet_cycles = 0;
    bit idle_on      = 1'b0;
    bit hold_req     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Left and right bounds of the counting region on row r (top_row <= r < frame_height).
    function automatic void row_span(input int r, output int lo, output int hi);
        int drop;
        drop = (int'(cur_top_left) * (r - int'(cur_top))) / (int'(cur_height) - int'(cur_top));
        lo   = int'(cur_top_left) - drop;
        hi   = int'(cur_width) - lo;
    endfunction

    function automatic logic [CNT_W-1:0] bumped(input logic [CNT_W-1:0] n);
        return (n == SAT_MAX) ? n : n + 1'b1;
    endfunction

    function automatic void apply_command(input uvdh_cmd_t cmd, input int r, c, d,
                                          output bit has_read, output bin_read_t rd,
                                          output bit counted);
        int               lo;
        int               hi;
        int               key;
        logic [CNT_W-1:0] n;
        has_read = 1'b0;
        counted  = 1'b0;
        n        = '0;
        case (cmd)
            CMD_ACC:
            begin
                if (d > int'(cur_disp_floor) && d < DISP_BINS_DEF && r >= int'(cur_top)
                    && r < int'(cur_height) && r < MAX_ROWS_DEF && c < MAX_COLS_DEF)
                begin
                    row_span(r, lo, hi);
                    if (c >= lo && c < hi)
                    begin
                        counted = 1'b1;
                        if (cur_en_v)
                        begin
                            key         = r * DISP_BINS_DEF + d;
                            v_bins[key] = v_bins.exists(key) ? bumped(v_bins[key]) : 8'd1;
                        end
                        if (cur_en_u)
                        begin
                            key         = d * MAX_COLS_DEF + c;
                            u_bins[key] = u_bins.exists(key) ? bumped(u_bins[key]) : 8'd1;
                        end
                    end
                end
            end
            CMD_CLR:
            begin
                v_bins.delete();
                u_bins.delete();
            end
            CMD_RDV:
            begin
                has_read = 1'b1;
                key      = r * DISP_BINS_DEF + d;
                if (d < DISP_BINS_DEF && r < MAX_ROWS_DEF && v_bins.exists(key))
                    n = v_bins[key];
            end
            CMD_RDU:
            begin
                has_read = 1'b1;
                key      = d * MAX_COLS_DEF + c;
                if (d < DISP_BINS_DEF && c < MAX_COLS_DEF && u_bins.exists(key))
                    n = u_bins[key];
            end
            default: ;
        endcase
        rd.bin_count  = n;
        rd.strong_res = (n > cur_count_floor);
    endfunction

    // Offers one command until it is transferred, then updates the predicted histograms.
    task automatic issue(input uvdh_cmd_t cmd, input int r, c, d, input bit typed,
                         input bin_read_t want, output bit effect);
        bit        has_read;
        bit        counted;
        bin_read_t rd;
        pixel_t    px;
        while (idle_on && $urandom_range(99) < 11)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.cmd       <= cmd;
        item_bus.row       <= r[ROW_W-1:0];
        item_bus.col       <= c[COL_W-1:0];
        item_bus.disparity <= d[DISP_W-1:0];
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        apply_command(cmd, r, c, d, has_read, rd, counted);
        if (has_read)
            pending_reads.insert(pending_reads.size(), typed ? want : rd);
        if (counted)
        begin
            px = '{r, c, d};
            recent_hits.insert(recent_hits.size(), px);
            if (recent_hits.size() > RECENT_HITS)
                void'(recent_hits.pop_front());
        end
        effect = has_read || counted || (cmd == CMD_CLR);
    endtask

    // Waits until every read has returned and any pixel still in flight has landed.
    task automatic settle();
        item_bus.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input uvdh_cfg_idx_t idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  cur_width       = val[FW_W-1:0];
            CFG_FRAME_HEIGHT: cur_height      = val[FH_W-1:0];
            CFG_TOP_ROW:      cur_top         = val[ROW_W-1:0];
            CFG_TOP_LEFT_COL: cur_top_left    = val[TLC_W-1:0];
            CFG_DISP_FLOOR:   cur_disp_floor  = val[DISP_W-1:0];
            CFG_COUNT_FLOOR:  cur_count_floor = val[CNT_W-1:0];
            CFG_ENABLE_U:     cur_en_u        = val[0];
            CFG_ENABLE_V:     cur_en_v        = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input int w, h, top, tl, dfl, cfl, eu, ev);
        settle();
        set_reg(CFG_FRAME_WIDTH, w);
        set_reg(CFG_FRAME_HEIGHT, h);
        set_reg(CFG_TOP_ROW, top);
        set_reg(CFG_TOP_LEFT_COL, tl);
        set_reg(CFG_DISP_FLOOR, dfl);
        set_reg(CFG_COUNT_FLOOR, cfl);
        set_reg(CFG_ENABLE_U, eu);
        set_reg(CFG_ENABLE_V, ev);
    endtask

    function automatic plan_step_t cmd_step(input uvdh_cmd_t cmd, input int r, c, d, reps,
                                            input bit typed, input int cnt, input bit is_strong);
        plan_step_t s;
        s.is_cfg         = 1'b0;
        s.reg_idx        = CFG_FRAME_WIDTH;
        s.reg_val        = 0;
        s.cmd            = cmd;
        s.r              = r;
        s.c              = c;
        s.d              = d;
        s.reps           = reps;
        s.typed          = typed;
        s.want.bin_count = cnt[CNT_W-1:0];
        s.want.strong_res = is_strong;
        return s;
    endfunction

    function automatic plan_step_t cfg_step(input uvdh_cfg_idx_t idx, input int val);
        plan_step_t s;
        s         = cmd_step(CMD_ACC, 0, 0, 0, 0, 1'b0, 0, 1'b0);
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    initial
    begin : stimulus
        plan_step_t plan [$];
        int         hot_row [4];
        int         hot_col [4];
        int         hot_disp [4];
        int         npool;
        int         goal;
        int         done;
        int         w;
        int         h;
        int         r;
        int         c;
        int         d;
        int         lo;
        int         hi;
        int         pick;
        bit         effect;
        pixel_t     px;
        uvdh_cmd_t  cmd;

        item_bus.valid     = 1'b0;
        item_bus.cmd       = CMD_ACC;
        item_bus.row       = '0;
        item_bus.col       = '0;
        item_bus.disparity = '0;

        // Directed table, run under the reset configuration until the region rows.
        plan.insert(plan.size(), cmd_step(CMD_RDV, 0, 0, 0, 1, 1'b1, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_RDU, 0, 1023, 127, 1, 1'b1, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_ACC, 0, 0, 1, 1, 1'b0, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_RDV, 0, 0, 1, 1, 1'b1, 1, 1'b1));
        plan.insert(plan.size(), cmd_step(CMD_RDU, 0, 0, 1, 1, 1'b1, 1, 1'b1));
        plan.insert(plan.size(), cmd_step(CMD_ACC, 511, 1023, 127, 1, 1'b0, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_RDV, 511, 0, 127, 1, 1'b1, 1, 1'b1));
        plan.insert(plan.size(), cmd_step(CMD_RDU, 0, 1023, 127, 1, 1'b1, 1, 1'b1));
        // Disparity at the floor and disparities past the store are all dropped.
        plan.insert(plan.size(), cmd_step(CMD_ACC, 5, 5, 0, 1, 1'b0, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_ACC, 5, 5, 128, 1, 1'b0, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_ACC, 5, 5, 255, 1, 1'b0, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_RDV, 5, 0, 0, 1, 1'b1, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_RDV, 5, 0, 255, 1, 1'b1, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_RDU, 0, 5, 128, 1, 1'b1, 0, 1'b0));
        // Enough hits on one pixel to pin both bins at the saturation value.
        plan.insert(plan.size(), cmd_step(CMD_ACC, 9, 9, 9, 300, 1'b0, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_RDV, 9, 0, 9, 1, 1'b1, 255, 1'b1));
        plan.insert(plan.size(), cmd_step(CMD_RDU, 0, 9, 9, 1, 1'b1, 255, 1'b1));
        plan.insert(plan.size(), cmd_step(CMD_CLR, 0, 0, 0, 1, 1'b0, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_RDV, 9, 0, 9, 1, 1'b1, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_RDU, 0, 1023, 127, 1, 1'b1, 0, 1'b0));
        // Frame height at or below the top row leaves no rows to count.
        plan.insert(plan.size(), cfg_step(CFG_TOP_ROW, 300));
        plan.insert(plan.size(), cfg_step(CFG_FRAME_HEIGHT, 200));
        plan.insert(plan.size(), cmd_step(CMD_ACC, 400, 10, 10, 1, 1'b0, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_RDV, 400, 0, 10, 1, 1'b1, 0, 1'b0));
        // A left edge beyond half the width leaves an empty column span.
        plan.insert(plan.size(), cfg_step(CFG_FRAME_HEIGHT, 512));
        plan.insert(plan.size(), cfg_step(CFG_TOP_ROW, 0));
        plan.insert(plan.size(), cfg_step(CFG_FRAME_WIDTH, 100));
        plan.insert(plan.size(), cfg_step(CFG_TOP_LEFT_COL, 900));
        plan.insert(plan.size(), cmd_step(CMD_ACC, 0, 50, 10, 1, 1'b0, 0, 1'b0));
        plan.insert(plan.size(), cmd_step(CMD_RDU, 0, 50, 10, 1, 1'b1, 0, 1'b0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                set_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                repeat (plan[i].reps)
                    issue(plan[i].cmd, plan[i].r, plan[i].c, plan[i].d, plan[i].typed,
                          plan[i].want, effect);
            end
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: configure(1024, 512, 0, 0, 0, 0, 1, 1);
                1: configure(1024, 512, 511, 1023, 255, 255, 1, 1);
                2: configure(1, 1, 0, 0, 1, 0, 0, 1);
                3: configure(640, 400, 40, 300, 10, 128, 1, 1);
                default:
                begin
                    w = $urandom_range(1024, 1);
                    h = $urandom_range(512, 1);
                    configure(w, h,
                              ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(h - 1),
                              $urandom_range(1) ? $urandom_range(1023) : $urandom_range(w / 2),
                              $urandom_range(40), $urandom_range(30),
                              $urandom_range(3) != 0,
                              (ph == 7) ? 0 : ($urandom_range(3) != 0));
                end
            endcase

            // The first phase runs with no idling on either side.
            idle_on = (ph != 0);
            npool   = (ph == 3) ? 1 : 4;
            goal    = (ph == 3) ? 280 : 80;
            for (int k = 0; k < 4; k++)
            begin
                hot_row[k]  = (int'(cur_height) > int'(cur_top))
                            ? $urandom_range(int'(cur_height) - 1, int'(cur_top))
                            : $urandom_range(511);
                hot_disp[k] = (cur_disp_floor < 127)
                            ? $urandom_range(127, int'(cur_disp_floor) + 1)
                            : $urandom_range(255);
                hot_col[k]  = $urandom_range(1023);
            end
            if (ph == 4)
            begin
                issue(CMD_CLR, 0, 0, 0, 1'b0, '0, effect);
                recent_hits.delete();
            end
            // Stall the result side for a long stretch so reads back up into the input.
            if (ph == 5)
                hold_req = 1'b1;

            done = 0;
            while (done < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    cmd = CMD_ACC;
                    r   = hot_row[$urandom_range(npool - 1)];
                    d   = hot_disp[$urandom_range(npool - 1)];
                    c   = hot_col[$urandom_range(npool - 1)];
                    if (r >= int'(cur_top) && r < int'(cur_height))
                    begin
                        row_span(r, lo, hi);
                        if (hi > lo)
                            c = lo + c % (hi - lo);
                    end
                end
                else if (pick < 80 && recent_hits.size() != 0)
                begin
                    px  = recent_hits[$urandom_range(recent_hits.size() - 1)];
                    cmd = $urandom_range(1) ? CMD_RDV : CMD_RDU;
                    r   = px.r;
                    c   = px.c;
                    d   = px.d;
                end
                else
                begin
                    cmd = uvdh_cmd_t'($urandom_range(2));
                    r   = $urandom_range(511);
                    c   = $urandom_range(1023);
                    d   = $urandom_range(255);
                end
                issue(cmd, r, c, d, 1'b0, '0, effect);
                if (effect)
                    done++;
            end
        end

        settle();
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin : result_sink
        int        hold;
        bin_read_t want;
        hold             = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                if (pending_reads.size() == 0)
                begin
                    errors++;
                    $error("unexpected result transfer: bin_count %0d strong_res %0b",
                           result_bus.bin_count, result_bus.strong_res);
                end
                else
                begin
                    want = pending_reads.pop_front();
                    if (result_bus.bin_count !== want.bin_count)
                    begin
                        errors++;
                        $error("bin_count: expected %0d, actual %0d",
                               want.bin_count, result_bus.bin_count);
                    end
                    if (result_bus.strong_res !== want.strong_res)
                    begin
                        errors++;
                        $error("strong_res: expected %0b, actual %0b",
                               want.strong_res, result_bus.strong_res);
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold     = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= !(idle_on && $urandom_range(99) < 11);
        end
    end

    // The longest correct quiet stretch is one memory sweep after reset or a clear.
    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready)
            || (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

endmodule
